[rtl/aes_pkg.sv]
`default_nettype none
package aes_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_INIT,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    // premultiply then forward mix
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[i*8 +: 8] = inv ? INV_SBOX[s[i*8 +: 8]] : SBOX[s[i*8 +: 8]];
    end
    sub_bytes = r;
  endfunction

  // byte k of the block sits at bits 127-8k
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        if (inv) begin
          r[127 - 8*(rw + 4*((c + rw) % 4)) -: 8] = s[127 - 8*(rw + 4*c) -: 8];
        end else begin
          r[127 - 8*(rw + 4*c) -: 8] = s[127 - 8*(rw + 4*((c + rw) % 4)) -: 8];
        end
      end
    end
    shift_rows = r;
  endfunction

endpackage
`default_nettype wire

[rtl/aes128_block_cipher.sv]
`default_nettype none
// AES-128 ECB cipher. Load the key through cfg (index 0 key_high, 1 key_low), then
// send blocks with op 0 to encrypt or 1 to decrypt. A block goes from acceptance
// to result through an initial key addition state, ten rounds through a single
// shared round unit, and an output state that holds the result until out_ready;
// in_ready is low meanwhile. The unit is ready again in the cycle after the result
// leaves, so it never takes a new block before it is through with the last one.
// The first block after reset or a key write first runs the key schedule, with
// one round-key word made per cycle into a 44-word register file.
// Decryption uses the straight inverse cipher with the same round keys.
module aes128_block_cipher #(
  parameter int CfgIdxW = 1
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [CfgIdxW-1:0]   cfg_index,
  input  wire [63:0]          cfg_data,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 in_op,
  input  wire [63:0]          in_block_hi,
  input  wire [63:0]          in_block_lo,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [63:0]         out_result_hi,
  output logic [63:0]         out_result_lo
);
  import aes_pkg::*;

  aes_state_t state_r, state_nxt;
  logic [63:0]  key_hi_r, key_lo_r;
  logic         keys_ready_r;
  logic [0:3][31:0] rk_r [11];
  logic [5:0]   kidx_r;
  logic [7:0]   rcon_r;
  logic [127:0] st_r;
  logic         op_r;
  logic [3:0]   rnd_r;
  logic [31:0]  w3_r;
  logic [127:0] blk_r;

  logic         in_acc, out_acc, key_wr;
  logic [127:0] rk_cur, sr, sb, ak, mixed, rnd_out;
  logic [3:0]   rk_sel;
  logic [31:0]  kw_t, kw_new;

  function automatic logic [127:0] mix_col_all(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) r[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32]);
    mix_col_all = r;
  endfunction

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign key_wr  = cfg_we && (cfg_index == CfgIdxW'(0) || cfg_index == CfgIdxW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = keys_ready_r ? ST_INIT : ST_KEXP;
      ST_KEXP:  if (kidx_r == 6'd43) state_nxt = ST_INIT;
      ST_INIT:  state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 4'd10) state_nxt = ST_DONE;
      ST_DONE:  if (out_acc) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end

  assign out_result_hi = st_r[127:64];
  assign out_result_lo = st_r[63:0];

  // key schedule word unit
  always_comb begin
    kw_t = w3_r;
    if (kidx_r[1:0] == 2'd0) begin
      kw_t = {SBOX[w3_r[23:16]] ^ rcon_r, SBOX[w3_r[15:8]], SBOX[w3_r[7:0]],
              SBOX[w3_r[31:24]]};
    end
    kw_new = rk_r[kidx_r[5:2] - 4'd1][kidx_r[1:0]] ^ kw_t;
  end

  // shared round unit
  always_comb begin
    if (state_r == ST_INIT) rk_sel = op_r ? 4'd10 : 4'd0;
    else rk_sel = op_r ? 4'd10 - rnd_r : rnd_r;
    rk_cur = rk_r[rk_sel];
    sr = shift_rows(st_r, op_r);
    sb = sub_bytes(sr, op_r);
    ak = sb ^ rk_cur;
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32*c -: 32] = op_r ? inv_mix_col(ak[127 - 32*c -: 32])
                                     : mix_col(ak[127 - 32*c -: 32]);
    end
    if (!op_r) rnd_out = (rnd_r == 4'd10) ? ak : (mix_col_all(sb) ^ rk_cur);
    else rnd_out = (rnd_r == 4'd10) ? ak : mixed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      key_hi_r     <= '0;
      key_lo_r     <= '0;
      keys_ready_r <= 1'b0;
      kidx_r       <= '0;
      rnd_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == CfgIdxW'(0)) key_hi_r <= cfg_data;
      if (cfg_we && cfg_index == CfgIdxW'(1)) key_lo_r <= cfg_data;
      if (key_wr) keys_ready_r <= 1'b0;
      else if (state_r == ST_KEXP && kidx_r == 6'd43) keys_ready_r <= 1'b1;
      if (in_acc) kidx_r <= 6'd4;
      else if (state_r == ST_KEXP) kidx_r <= kidx_r + 6'd1;
      if (state_r == ST_INIT) rnd_r <= 4'd1;
      else if (state_r == ST_ROUND) rnd_r <= rnd_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_op;
      blk_r <= {in_block_hi, in_block_lo};
      if (!keys_ready_r) begin
        rk_r[0] <= {key_hi_r, key_lo_r};
        w3_r    <= key_lo_r[31:0];
        rcon_r  <= RCON_INIT;
      end
    end
    if (state_r == ST_KEXP) begin
      rk_r[kidx_r[5:2]][kidx_r[1:0]] <= kw_new;
      w3_r <= kw_new;
      if (kidx_r[1:0] == 2'd0) rcon_r <= xtime(rcon_r);
    end
    if (state_r == ST_INIT) st_r <= blk_r ^ rk_cur;
    else if (state_r == ST_ROUND) st_r <= rnd_out;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_round_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |=> (rnd_r == 4'd1)) else $error("round count");
  a_keys_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT && !$past(key_wr)) |-> keys_ready_r) else $error("keys not ready");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(st_r))) else $error("result dropped");

endmodule
`default_nettype wire

[tb/aes128_block_cipher_test.sv]
`timescale 1ns / 1ps

module aes128_block_cipher_test;
  import aes_pkg::*;

  localparam logic [1:0] KEY_HIGH_IDX = 2'd0;
  localparam logic [1:0] KEY_LOW_IDX = 2'd1;
  localparam logic [1:0] SPARE_IDX = 2'd2;
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;
  localparam logic [7:0] MIX_FWD [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
  localparam logic [7:0] MIX_INV [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
  localparam int STALL_LEN = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic         op;
    logic [127:0] blk;
    logic         undo_last;
  } block_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = 1'b0;
  logic [63:0] in_block_hi = '0;
  logic [63:0] in_block_lo = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_result_hi;
  logic [63:0] out_result_lo;

  block_item_t blocks_to_send[$];
  logic [127:0] expected_blocks[$];
  logic [63:0] key_hi_m = '0;
  logic [63:0] key_lo_m = '0;
  logic [31:0] sched [44];
  logic sched_ok = 1'b0;
  logic [127:0] last_out = '0;
  int n_in = 0;
  int n_out = 0;
  int n_enc = 0;
  int n_dec = 0;
  int n_keys = 0;
  int mismatches = 0;
  int stall_left = 0;
  bit stalled_once = 0;
  int quiet_cycles = 0;
  block_item_t drv;
  logic [127:0] want;

  aes128_block_cipher #(.CfgIdxW(2)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_block_hi(in_block_hi), .in_block_lo(in_block_lo),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_hi(out_result_hi), .out_result_lo(out_result_lo)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) acc ^= b;
      b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic void build_schedule();
    logic [31:0] t;
    logic [7:0] rc;
    rc = 8'h01;
    sched[0] = key_hi_m[63:32];
    sched[1] = key_hi_m[31:0];
    sched[2] = key_lo_m[63:32];
    sched[3] = key_lo_m[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]} ^ {rc, 24'h0};
        rc = gf_mult(rc, 8'h02);
      end
      sched[i] = sched[i-4] ^ t;
    end
    sched_ok = 1'b1;
  endfunction

  function automatic logic [127:0] round_key(input int r);
    return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
  endfunction

  function automatic logic [127:0] sub_all(input logic [127:0] v, input logic dec);
    for (int k = 0; k < 16; k++)
      v[127-8*k -: 8] = dec ? INV_SBOX[v[127-8*k -: 8]] : SBOX[v[127-8*k -: 8]];
    return v;
  endfunction

  function automatic logic [127:0] rotate_rows(input logic [127:0] v, input logic dec);
    logic [127:0] r;
    int o;
    r = v;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        o = rw + 4 * ((c + rw) % 4);
        if (dec) r[127-8*o -: 8] = v[127-8*(rw+4*c) -: 8];
        else r[127-8*(rw+4*c) -: 8] = v[127-8*o -: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] v, input logic dec);
    logic [127:0] r;
    logic [7:0] acc;
    r = v;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc ^= gf_mult(dec ? MIX_INV[(k-rw+4)%4] : MIX_FWD[(k-rw+4)%4],
                         v[127-8*(4*c+k) -: 8]);
        r[127-8*(4*c+rw) -: 8] = acc;
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] cipher_block(input logic dec, input logic [127:0] v);
    if (!sched_ok) build_schedule();
    if (!dec) begin
      v ^= round_key(0);
      for (int r = 1; r < 10; r++)
        v = mix_all(rotate_rows(sub_all(v, 1'b0), 1'b0), 1'b0) ^ round_key(r);
      v = rotate_rows(sub_all(v, 1'b0), 1'b0) ^ round_key(10);
    end else begin
      v ^= round_key(10);
      for (int r = 9; r >= 1; r--)
        v = mix_all(sub_all(rotate_rows(v, 1'b1), 1'b1) ^ round_key(r), 1'b1);
      v = sub_all(rotate_rows(v, 1'b1), 1'b1) ^ round_key(0);
    end
    return v;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        last_out = cipher_block(in_op, {in_block_hi, in_block_lo});
        expected_blocks.push_back(last_out);
        n_in++;
        if (in_op == OP_DEC) n_dec++;
        else n_enc++;
      end
      if (!in_valid || in_ready) begin
        if (blocks_to_send.size() > 0
            && ((n_in >= 600 && n_in < 800) || $urandom_range(99) >= 35)) begin
          drv = blocks_to_send.pop_front();
          if (drv.undo_last) begin
            drv.op = OP_DEC;
            drv.blk = last_out;
          end
          in_valid <= 1'b1;
          in_op <= drv.op;
          in_block_hi <= drv.blk[127:64];
          in_block_lo <= drv.blk[63:0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h %h", out_result_hi, out_result_lo);
        end else begin
          want = expected_blocks.pop_front();
          if (want[127:64] !== out_result_hi || want[63:0] !== out_result_lo) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on result %0d: expected hi %h lo %h, got hi %h lo %h",
                       n_out, want[127:64], want[63:0], out_result_hi, out_result_lo);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (n_out == 60 && !stalled_once) begin
        stalled_once = 1;
        stall_left = STALL_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (n_in >= 600 && n_in < 800) || $urandom_range(99) >= 35;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("aes128_block_cipher_test: done, errors");
      $finish;
    end
  end

  task automatic queue_block(input logic op, input logic [127:0] blk, input bit undo = 0);
    block_item_t it;
    it.op = op;
    it.blk = blk;
    it.undo_last = undo;
    blocks_to_send.push_back(it);
  endtask

  task automatic queue_random(input int count);
    logic [127:0] b;
    for (int i = 0; i < count; i++) begin
      b = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(19))
        0: b = '0;
        1: b = '1;
        default: ;
      endcase
      queue_block(logic'($urandom_range(1)), b, $urandom_range(4) == 0);
    end
  endtask

  task automatic drain();
    while (blocks_to_send.size() > 0 || in_valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      KEY_HIGH_IDX: begin
        key_hi_m = v;
        sched_ok = 1'b0;
      end
      KEY_LOW_IDX: begin
        key_lo_m = v;
        sched_ok = 1'b0;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    write_reg(KEY_HIGH_IDX, hi);
    write_reg(KEY_LOW_IDX, lo);
    n_keys++;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset key, all zero
    queue_block(OP_ENC, '0);
    queue_block(OP_DEC, '0);
    queue_block(OP_ENC, '1);
    queue_block(OP_DEC, '1);
    queue_block(OP_ENC, {16{8'h5a}});
    queue_block(OP_DEC, {16{8'ha5}});
    queue_block(OP_ENC, 128'h1);
    queue_block(OP_DEC, 128'h0, 1);
    queue_random(12);
    drain();

    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    queue_block(OP_ENC, 128'h00112233445566778899aabbccddeeff);
    queue_block(OP_DEC, 128'h69c4e0d86a7b0430d8cdb78070b4c55a);
    queue_random(300);
    drain();

    write_reg(KEY_LOW_IDX, '1);
    queue_random(150);
    drain();

    // spare index must leave key and schedule untouched
    write_reg(SPARE_IDX, {$urandom, $urandom});
    queue_random(100);
    drain();

    set_key('1, '1);
    queue_random(150);
    drain();

    write_reg(KEY_HIGH_IDX, '0);
    queue_random(10);
    drain();

    set_key('0, '0);
    queue_random(150);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_key({$urandom, $urandom}, {$urandom, $urandom});
      queue_random(160);
      drain();
    end

    $display("%0d blocks encrypted and %0d decrypted under %0d key settings,",
             n_enc, n_dec, n_keys);
    $display("%0d results checked, %0d mismatches", n_out, mismatches);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("aes128_block_cipher_test: done, clean");
    end else begin
      $display("aes128_block_cipher_test: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/aes_pkg.sv
rtl/aes128_block_cipher.sv
tb/aes128_block_cipher_test.sv
